[rtl/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam logic [1:0] REG_CAL_A = 2'd0;
    localparam logic [1:0] REG_CAL_B = 2'd1;
    localparam logic [1:0] REG_CAL_C = 2'd2;
    localparam logic [1:0] REG_OSS   = 2'd3;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] B7_LARGE   = 32'h8000_0000;
    localparam logic [31:0] P_COEF_SQ  = 32'd3038;
    localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_OFFSET   = 32'd3791;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic        sgn;      // signed operands, truncating quotient
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

endpackage

[rtl/btpc_div.sv]
// ----------------------------------------------------------------------------
// btpc_div
// Radix-2 restoring divider, 32-bit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btpc_div
    import btpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [31:0] num_abs;
    logic [31:0] den_abs;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign num_abs = (req.sgn && req.num[31]) ? (32'd0 - req.num) : req.num;
    assign den_abs = (req.sgn && req.den[31]) ? (32'd0 - req.den) : req.den;
    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                rem_reg  <= '0;
                quo_reg  <= num_abs;
                den_reg  <= den_abs;
                neg_reg  <= req.sgn && (req.num[31] ^ req.den[31]);
            end
            else if (busy_reg)
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

[rtl/baro_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// One transaction at a time. A temperature or pressure item raises out_valid
// once its steps and its division are done, and holds it through any
// out_ready stall. The time is set by a radix-2 divider that holds the
// sequencer for the whole of each division (one division per item) and by one
// shared, registered 32x32 multiplier stepped by a sequencer. A zero divisor
// skips the division, so a faulting item reaches out_valid sooner after
// acceptance. in_ready is low from acceptance until the result has been taken.
// Configuration is written only while idle.
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [23:0]        raw_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [15:0] temperature_tenths,
    output logic signed [31:0] pressure_pa,
    output logic               divide_fault
);

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_T3, S_TDIV, S_TFIN,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_PDIV, S_PQ, S_Q1, S_Q2, S_Q3, S_Q4, S_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] cal_a_reg, cal_b_reg;
    logic [47:0] cal_c_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg;
    logic        kind_reg;
    logic [23:0] raw_reg;
    logic [31:0] x1_reg, b6_reg, sq_reg, acc_reg, b3_reg, b4_reg, p_reg;
    logic [31:0] prod_reg;
    logic        big_reg;
    logic [15:0] temp_reg;
    logic [31:0] pres_reg;
    logic        fault_reg;

    // shared multiplier, registered
    logic [31:0] ma, mb;
    div_req_t    dreq;
    div_rsp_t    drsp;

    btpc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic [31:0] sx(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
        return 32'($signed(x) >>> s);
    endfunction

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx(cal_a_reg[63:48]);
    assign ac2 = sx(cal_a_reg[47:32]);
    assign ac3 = sx(cal_a_reg[31:16]);
    assign ac4 = {16'd0, cal_a_reg[15:0]};
    assign ac5 = {16'd0, cal_b_reg[63:48]};
    assign ac6 = {16'd0, cal_b_reg[47:32]};
    assign b1  = sx(cal_b_reg[31:16]);
    assign b2  = sx(cal_b_reg[15:0]);
    assign mc  = sx(cal_c_reg[31:16]);
    assign md  = sx(cal_c_reg[15:0]);

    logic [31:0] up;
    assign up = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});

    logic [31:0] den_temp, b3_new, b5_new, t_sh, p_sh;
    assign den_temp = x1_reg + md;
    assign b3_new   = asr((((ac1 << 2) + acc_reg) << oss_reg) + 32'd2, 5'd2);
    assign b5_new   = x1_reg + drsp.quo;
    assign t_sh     = asr(b5_new + 32'd8, 5'd4);
    assign p_sh     = asr(p_reg, 5'd8);

    // product of the operands set in one state is read in the next
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_T1:    begin ma = {16'd0, raw_reg[15:0]} - ac6; mb = ac5; end
            S_P1:    begin ma = b6_reg; mb = b6_reg; end
            S_P2:    begin ma = ac2;    mb = b6_reg; end
            S_P3:    begin ma = b2;     mb = sq_reg; end
            S_P4:    begin ma = ac3;    mb = b6_reg; end
            S_P5:    begin ma = b1;     mb = sq_reg; end
            S_P7:    begin ma = ac4;    mb = acc_reg + B4_BIAS; end
            S_P8:    begin ma = up - b3_reg; mb = B7_SCALE >> oss_reg; end
            S_PQ:    begin ma = p_sh;   mb = p_sh; end
            S_Q1:    begin ma = prod_reg; mb = P_COEF_SQ; end
            S_Q2:    begin ma = P_COEF_LIN; mb = p_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.sgn   = 1'b1;
        dreq.num   = mc << 11;
        dreq.den   = den_temp;
        if (state_reg == S_T3 && den_temp != 32'd0)
            dreq.start = 1'b1;
        // B7 is the product coming out of the multiplier in this state
        if (state_reg == S_P9 && b4_reg != 32'd0)
        begin
            dreq.start = 1'b1;
            dreq.sgn   = 1'b0;
            dreq.num   = (prod_reg >= B7_LARGE) ? prod_reg : (prod_reg << 1);
            dreq.den   = b4_reg;
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign result_kind        = kind_reg;
    assign temperature_tenths = temp_reg;
    assign pressure_pa        = pres_reg;
    assign divide_fault       = fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= 2'd3;
            b5_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_CAL_A: cal_a_reg <= cfg_data;
                            REG_CAL_B: cal_b_reg <= cfg_data;
                            REG_CAL_C: cal_c_reg <= cfg_data[47:0];
                            REG_OSS:   oss_reg   <= cfg_data[1:0];
                            default:   ;
                        endcase
                    end
                    if (in_valid)
                    begin
                        kind_reg  <= kind;
                        raw_reg   <= raw_value;
                        temp_reg  <= '0;
                        pres_reg  <= '0;
                        fault_reg <= 1'b0;
                        b6_reg    <= b5_reg - B6_OFFSET;
                        state_reg <= kind ? S_P1 : S_T1;
                    end
                end
                S_T1: state_reg <= S_T2;
                S_T2:
                begin
                    x1_reg <= asr(prod_reg, 5'd15);
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    if (den_temp == 32'd0)
                    begin
                        fault_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_TDIV;
                end
                S_TDIV:
                begin
                    if (drsp.done)
                        state_reg <= S_TFIN;
                end
                S_TFIN:
                begin
                    b5_reg <= b5_new;
                    if ($signed(t_sh) > 32'sd32767)
                        temp_reg <= 16'h7FFF;
                    else if ($signed(t_sh) < -32'sd32768)
                        temp_reg <= 16'h8000;
                    else
                        temp_reg <= t_sh[15:0];
                    state_reg <= S_OUT;
                end
                S_P1: state_reg <= S_P2;
                S_P2:
                begin
                    sq_reg <= asr(prod_reg, 5'd12);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    acc_reg <= asr(prod_reg, 5'd11);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    acc_reg <= acc_reg + asr(prod_reg, 5'd11);
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    b3_reg  <= b3_new;
                    acc_reg <= asr(prod_reg, 5'd13);
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    acc_reg <= asr(acc_reg + asr(prod_reg, 5'd16) + 32'd2, 5'd2);
                    state_reg <= S_P7;
                end
                S_P7: state_reg <= S_P8;
                S_P8:
                begin
                    b4_reg <= prod_reg >> 15;
                    state_reg <= S_P9;
                end
                S_P9:
                begin
                    big_reg <= (prod_reg >= B7_LARGE);
                    state_reg <= S_PDIV;
                end
                S_PDIV:
                begin
                    if (b4_reg == 32'd0)
                    begin
                        fault_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (drsp.done)
                    begin
                        p_reg <= big_reg ? (drsp.quo << 1) : drsp.quo;
                        state_reg <= S_PQ;
                    end
                end
                S_PQ: state_reg <= S_Q1;
                S_Q1: state_reg <= S_Q2;
                S_Q2:
                begin
                    acc_reg <= asr(prod_reg, 5'd16);
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    acc_reg <= acc_reg + asr(prod_reg, 5'd16) + P_OFFSET;
                    state_reg <= S_Q4;
                end
                S_Q4:
                begin
                    pres_reg <= p_reg + asr(acc_reg, 5'd4);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("ready while result pending");
    a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind) |-> (temperature_tenths == 16'sd0))
        else $error("temperature nonzero in pressure result");
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_fault) |->
            (pressure_pa == 32'sd0 && temperature_tenths == 16'sd0))
        else $error("fault result not zero");

endmodule
